>>> hdl/hsl_pkg.sv
package hsl_pkg;

  // field and datapath widths
  localparam int HUE_W = 9;
  localparam int PCT_W = 7;
  localparam int CH_W  = 8;
  localparam int T_W   = 14;   // t1/t2/diff in 1/10000 units, max 10000
  localparam int WT_W  = 6;    // hue weight, 0..60
  localparam int NUM_W = 20;   // channel numerator, max 600000
  localparam int X_W   = 28;   // 255*num + rounding bias
  localparam int M_W   = 19;   // reciprocal constant width
  localparam int Q_W   = 9;    // estimated quotient
  localparam int P_W   = X_W + M_W;   // reciprocal product

  // register stages inside one channel pipe
  localparam int CH_LAT = 3;

  // hue positions in degrees
  localparam logic [HUE_W-1:0] HUE_TURN       = 9'd360;
  localparam logic [HUE_W-1:0] HUE_THIRD      = 9'd120;
  localparam logic [HUE_W-1:0] HUE_SIXTH      = 9'd60;
  localparam logic [HUE_W-1:0] HUE_HALF       = 9'd180;
  localparam logic [HUE_W-1:0] HUE_TWO_THIRDS = 9'd240;

  // percent limits
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_HALF = 7'd50;

  // divide by 600000 through floor(2^38 / 600000), then one correction step
  localparam logic [NUM_W-1:0] DIV_DEN    = 20'd600000;
  localparam logic [X_W-1:0]   ROUND_HALF = 28'd300000;
  localparam logic [M_W-1:0]   RECIP_M    = 19'd458129;
  localparam int               RECIP_SH   = 38;

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  typedef logic [WT_W-1:0] wt_t;

  // luminance terms shared by all three channels
  typedef struct packed {
    logic [T_W-1:0] t2;
    logic [T_W-1:0] diff;
  } lum_t;

  // side-band that travels with each word
  typedef struct packed {
    logic            vld;
    logic            zero;
    logic [CH_W-1:0] gray;
  } ctl_t;

endpackage

>>> hdl/hsl_prep.sv
module hsl_prep import hsl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [HUE_W-1:0] hue,
  input  logic [PCT_W-1:0] sat,
  input  logic [PCT_W-1:0] lig,
  output ctl_t             ctl,
  output lum_t             lum,
  output wt_t              wt_red,
  output wt_t              wt_green,
  output wt_t              wt_blue
);

  // four-piece hue function as a weight on diff (0..60)
  function automatic wt_t hue_weight(input logic [HUE_W-1:0] pos);
    wt_t w;
    priority if (pos < HUE_SIXTH) begin
      w = WT_W'(pos);
    end else if (pos < HUE_HALF) begin
      w = WT_W'(HUE_SIXTH);
    end else if (pos < HUE_TWO_THIRDS) begin
      w = WT_W'(HUE_TWO_THIRDS - pos);
    end else begin
      w = '0;
    end
    return w;
  endfunction

  // stage A: wrap hue, clamp percentages, hue weights
  logic             vld_a_r;
  logic [PCT_W-1:0] sat_a_r, lig_a_r;
  wt_t              wr_a_r, wg_a_r, wb_a_r;

  logic [HUE_W-1:0] hue_m, pos_red, pos_blue;
  logic [HUE_W:0]   sum_red;
  logic [PCT_W-1:0] sat_c, lig_c;

  always_comb begin
    hue_m   = (hue >= HUE_TURN) ? hue - HUE_TURN : hue;
    sum_red = (HUE_W+1)'(hue_m) + (HUE_W+1)'(HUE_THIRD);
    pos_red = (sum_red > (HUE_W+1)'(HUE_TURN)) ? HUE_W'(sum_red - (HUE_W+1)'(HUE_TURN))
                                               : HUE_W'(sum_red);
    pos_blue = (hue_m >= HUE_THIRD) ? hue_m - HUE_THIRD : hue_m + HUE_TWO_THIRDS;
    sat_c = (sat > PCT_FULL) ? PCT_FULL : sat;
    lig_c = (lig > PCT_FULL) ? PCT_FULL : lig;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
    end
    sat_a_r <= sat_c;
    lig_a_r <= lig_c;
    wr_a_r  <= hue_weight(pos_red);
    wg_a_r  <= hue_weight(hue_m);
    wb_a_r  <= hue_weight(pos_blue);
  end

  // stage B: t2, diff = t1 - t2, and the gray level
  logic [T_W-1:0]  ls, l100, s100, t2_nxt, diff_nxt;
  logic [T_W:0]    diff_hi;
  logic [12:0]     lig51;
  logic [21:0]     gray_prod;
  logic [CH_W-1:0] gray_nxt;

  always_comb begin
    ls   = T_W'(lig_a_r) * T_W'(sat_a_r);
    l100 = T_W'(lig_a_r) * T_W'(PCT_FULL);
    s100 = T_W'(sat_a_r) * T_W'(PCT_FULL);
    diff_hi = {s100, 1'b0} - {ls, 1'b0};
    if (lig_a_r < PCT_HALF) begin
      t2_nxt   = l100 - ls;
      diff_nxt = {ls[T_W-2:0], 1'b0};
    end else begin
      t2_nxt   = l100 - s100 + ls;
      diff_nxt = diff_hi[T_W-1:0];
    end
    // lig*255/100 = floor(floor(lig*51/4) / 5), /5 by 1639/8192
    lig51     = 13'(lig_a_r) * 13'd51;
    gray_prod = 22'(lig51[12:2]) * 22'd1639;
    gray_nxt  = gray_prod[20:13];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl.vld <= 1'b0;
    end else begin
      ctl.vld <= vld_a_r;
    end
    ctl.zero <= (sat_a_r == '0);
    ctl.gray <= gray_nxt;
    lum.t2   <= t2_nxt;
    lum.diff <= diff_nxt;
    wt_red   <= wr_a_r;
    wt_green <= wg_a_r;
    wt_blue  <= wb_a_r;
  end

endmodule

>>> hdl/hsl_chan.sv
module hsl_chan import hsl_pkg::*; (
  input  logic            clk,
  input  lum_t            lum,
  input  wt_t             wt,
  output logic [CH_W-1:0] ch
);

  // stage C: numerator over 600000
  logic [NUM_W-1:0] num_r;

  always_ff @(posedge clk) begin
    num_r <= NUM_W'(lum.t2) * NUM_W'(HUE_SIXTH) + NUM_W'(lum.diff) * NUM_W'(wt);
  end

  // stage D: scale by 255, add rounding bias, reciprocal estimate
  logic [X_W-1:0] x_nxt, x_r;
  logic [P_W-1:0] prod;
  logic [Q_W-1:0] q0_r;

  always_comb begin
    x_nxt = {num_r, 8'b0} - X_W'(num_r) + ROUND_HALF;
    prod  = P_W'(x_nxt) * P_W'(RECIP_M);
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    q0_r <= prod[P_W-1:RECIP_SH];
  end

  // stage E: estimate is low by at most one, fix it and clamp
  logic [X_W:0]   qd, rem;
  logic [Q_W-1:0] qf;

  always_comb begin
    qd  = (X_W+1)'(q0_r) * (X_W+1)'(DIV_DEN);
    rem = (X_W+1)'(x_r) - qd;
    qf  = (rem >= (X_W+1)'(DIV_DEN)) ? q0_r + Q_W'(1) : q0_r;
  end

  always_ff @(posedge clk) begin
    ch <= (qf > Q_W'(CH_MAX)) ? CH_MAX : qf[CH_W-1:0];
  end

endmodule

>>> hdl/hsl_to_rgb_converter.sv
// HSL to RGB converter. One word (hue in degrees, saturation and lightness
// in percent) may be started every clock; busy is always low. Each result
// shows on out_red/out_green/out_blue for one cycle with out_valid high,
// after the start has passed two stages of hue/luminance prep,
// three stages per channel (numerator multiply, reciprocal multiply,
// correction and clamp) and the output register. The receiver must take
// every result when it appears. Hue 360..511 wraps modulo 360; saturation
// and lightness above 100 count as 100.
module hsl_to_rgb_converter import hsl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [HUE_W-1:0] in_hue_degrees,
  input  logic [PCT_W-1:0] in_saturation_pct,
  input  logic [PCT_W-1:0] in_lightness_pct,
  output logic             out_valid,
  output logic [CH_W-1:0]  out_red,
  output logic [CH_W-1:0]  out_green,
  output logic [CH_W-1:0]  out_blue
);

  // never stalls
  assign busy = 1'b0;

  ctl_t            ctl_p;
  lum_t            lum_p;
  wt_t             wt_r, wt_g, wt_b;
  logic [CH_W-1:0] ch_r, ch_g, ch_b;

  hsl_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start),
    .hue      (in_hue_degrees),
    .sat      (in_saturation_pct),
    .lig      (in_lightness_pct),
    .ctl      (ctl_p),
    .lum      (lum_p),
    .wt_red   (wt_r),
    .wt_green (wt_g),
    .wt_blue  (wt_b)
  );

  hsl_chan u_chan_red   (.clk(clk), .lum(lum_p), .wt(wt_r), .ch(ch_r));
  hsl_chan u_chan_green (.clk(clk), .lum(lum_p), .wt(wt_g), .ch(ch_g));
  hsl_chan u_chan_blue  (.clk(clk), .lum(lum_p), .wt(wt_b), .ch(ch_b));

  // side-band delay matching the channel pipes
  ctl_t ctl_d_r [CH_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CH_LAT; i++) begin
        ctl_d_r[i].vld <= 1'b0;
      end
    end else begin
      ctl_d_r[0].vld <= ctl_p.vld;
      for (int i = 1; i < CH_LAT; i++) begin
        ctl_d_r[i].vld <= ctl_d_r[i-1].vld;
      end
    end
    ctl_d_r[0].zero <= ctl_p.zero;
    ctl_d_r[0].gray <= ctl_p.gray;
    for (int i = 1; i < CH_LAT; i++) begin
      ctl_d_r[i].zero <= ctl_d_r[i-1].zero;
      ctl_d_r[i].gray <= ctl_d_r[i-1].gray;
    end
  end

  // output register: gray level when saturation is zero
  logic            out_valid_r;
  logic [CH_W-1:0] out_red_r, out_green_r, out_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_d_r[CH_LAT-1].vld;
    end
    out_red_r   <= ctl_d_r[CH_LAT-1].zero ? ctl_d_r[CH_LAT-1].gray : ch_r;
    out_green_r <= ctl_d_r[CH_LAT-1].zero ? ctl_d_r[CH_LAT-1].gray : ch_g;
    out_blue_r  <= ctl_d_r[CH_LAT-1].zero ? ctl_d_r[CH_LAT-1].gray : ch_b;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  // every started word comes out on out_valid
  a_start_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_valid)
    else $error("started word did not come out after 6 cycles");

  // no result without a start
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 6))
    else $error("result without a matching start");

  // zero saturation gives gray
  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_saturation_pct == '0, 6))
      |-> (out_red == out_green && out_green == out_blue))
    else $error("zero saturation did not give gray");

endmodule
